// File: sv/pinned_lru_variant_cache_defines.svh
// ----------------------------------------------------------------------------
// pinned_lru_variant_cache_defines
// assertion macros shared by the variant cache rtl
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_VARIANT_CACHE_DEFINES_SVH
`define PINNED_LRU_VARIANT_CACHE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PLVC_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PLVC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: sv/plvc_pkg.sv
// ----------------------------------------------------------------------------
// plvc_pkg
// shared types and constants of the pinned lru variant cache
// ----------------------------------------------------------------------------
package plvc_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int MAX_ROLES_DEF  = 16;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [12:0] SIZE_LIMIT = 13'd4096;

  localparam logic [2:0] ST_HIT         = 3'd0;
  localparam logic [2:0] ST_FILLED      = 3'd1;
  localparam logic [2:0] ST_INVALID     = 3'd2;
  localparam logic [2:0] ST_ALL_PINNED  = 3'd3;
  localparam logic [2:0] ST_OPEN_FAILED = 3'd4;
  localparam logic [2:0] ST_LAYOUT      = 3'd5;

  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam logic [1:0] REG_NUM_ROLES    = 2'd1;

  typedef struct packed {
    logic [3:0]  role;
    logic [12:0] size;
    logic        italic;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic hit;
    logic take;
  } cmp_res_t;

endpackage

// File: sv/plvc_ram.sv
// ----------------------------------------------------------------------------
// plvc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module plvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/plvc_cmp.sv
// ----------------------------------------------------------------------------
// plvc_cmp
// shared key match and victim compare unit, one slot per cycle
// ----------------------------------------------------------------------------
module plvc_cmp #(
  parameter int STAMP_BITS = plvc_pkg::STAMP_BITS_DEF
) (
  input  plvc_pkg::key_t         req,
  input  plvc_pkg::key_t         entry_key,
  input  logic [STAMP_BITS-1:0]  entry_stamp,
  input  logic                   entry_valid,
  input  logic                   entry_pinned,
  input  logic                   have,
  input  logic [STAMP_BITS-1:0]  best,
  output plvc_pkg::cmp_res_t     res,
  output logic [STAMP_BITS-1:0]  stamp_eff
);

  import plvc_pkg::*;

  // empty slots count as stamp zero
  assign stamp_eff = entry_valid ? entry_stamp : '0;
  assign res.hit   = entry_valid && (entry_key == req);
  assign res.take  = !entry_pinned && (!have || (stamp_eff < best));

endmodule

// File: sv/pinned_lru_variant_cache.sv
// ----------------------------------------------------------------------------
// pinned_lru_variant_cache
// fully associative variant cache with lru replacement and pinning
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. mode 0 looks up the
// key (role_index, pixels, italic); mode 1 begins a layout and unpins all
// active slots. Each word gives one result: done is high for one cycle with
// status and slot. The receiver cannot stall, so results are never held.
// Begin layout and invalid lookups answer in the cycle after start and
// leave busy low. A valid lookup scans the active slots one per cycle
// through the entry ram and the shared compare unit, which sees registered
// read data in the cycle after the address: a hit or the last slot ends
// the scan. Busy stays high for the whole scan, so no new word is taken
// until its result is out.
// cfg_we writes slots_in_use (index 0) or num_roles (index 1) from
// cfg_data; write only while idle. Synchronous reset empties all slots,
// clears pins and the use clock, and sets slots_in_use 16 and num_roles 1.
// No clearing pass is needed: per-slot valid bits mask the ram contents.
// ----------------------------------------------------------------------------
`include "pinned_lru_variant_cache_defines.svh"

module pinned_lru_variant_cache #(
  parameter int SLOTS      = plvc_pkg::SLOTS_DEF,
  parameter int MAX_ROLES  = plvc_pkg::MAX_ROLES_DEF,
  parameter int STAMP_BITS = plvc_pkg::STAMP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [3:0]  role_index,
  input  logic [12:0] pixels,
  input  logic        italic,
  input  logic        open_ok,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  import plvc_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int WW = KEY_W + STAMP_BITS;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  logic [0:0]            state;
  logic [4:0]            slots_in_use;
  logic [4:0]            num_roles;
  logic [STAMP_BITS-1:0] use_clock;
  logic [SLOTS-1:0]      valid_bits;
  logic [SLOTS-1:0]      pinned_bits;

  key_t                  req;
  logic                  req_open;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [AW-1:0]         pidx;
  logic                  have;
  logic [AW-1:0]         vic;
  logic [STAMP_BITS-1:0] best;

  logic [CW-1:0]         n_eff;
  logic                  accept;
  logic                  req_ok;
  key_t                  in_key;
  logic [STAMP_BITS-1:0] clock_inc;
  logic [STAMP_BITS-1:0] clock_next;
  logic                  pend_last;

  logic [WW-1:0]         rdata;
  logic                  ram_we;
  logic [AW-1:0]         waddr;
  key_t                  entry_key;
  logic [STAMP_BITS-1:0] entry_stamp;
  cmp_res_t              res;
  logic [STAMP_BITS-1:0] stamp_eff;
  logic                  have_n;
  logic [AW-1:0]         vic_n;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n_eff  = (int'(slots_in_use) > SLOTS) ? CW'(SLOTS) : CW'(slots_in_use);
  assign req_ok = (int'(role_index) < int'(num_roles)) && (int'(role_index) < MAX_ROLES) &&
                  (pixels != 13'd0) && (pixels <= SIZE_LIMIT);

  assign in_key.role   = role_index;
  assign in_key.size   = pixels;
  assign in_key.italic = italic;

  // use clock wraps to one, never zero
  assign clock_inc  = use_clock + STAMP_BITS'(1);
  assign clock_next = (clock_inc == '0) ? STAMP_BITS'(1) : clock_inc;

  assign pend_last   = ((CW'(pidx) + CW'(1)) == n_eff);
  assign entry_key   = key_t'(rdata[WW-1 -: KEY_W]);
  assign entry_stamp = rdata[STAMP_BITS-1:0];

  plvc_cmp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_cmp (
    .req          (req),
    .entry_key    (entry_key),
    .entry_stamp  (entry_stamp),
    .entry_valid  (valid_bits[pidx]),
    .entry_pinned (pinned_bits[pidx]),
    .have         (have),
    .best         (best),
    .res          (res),
    .stamp_eff    (stamp_eff)
  );

  assign have_n = have || res.take;
  assign vic_n  = res.take ? pidx : vic;
  assign ram_we = (state == S_SCAN) && pend &&
                  (res.hit || (pend_last && have_n && req_open));
  assign waddr  = res.hit ? pidx : vic_n;

  plvc_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({req, use_clock}),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      slots_in_use <= 5'd16;
      num_roles    <= 5'd1;
      use_clock    <= '0;
      valid_bits   <= '0;
      pinned_bits  <= '0;
      pend         <= 1'b0;
      have         <= 1'b0;
      idx          <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOTS_IN_USE: slots_in_use <= cfg_data;
          REG_NUM_ROLES:    num_roles    <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (CW'(i) < n_eff) begin
                  pinned_bits[i] <= 1'b0;
                end
              end
              done   <= 1'b1;
              status <= ST_LAYOUT;
              slot   <= 4'd0;
            end else if (!req_ok) begin
              done   <= 1'b1;
              status <= ST_INVALID;
              slot   <= 4'd0;
            end else begin
              use_clock <= clock_next;
              req       <= in_key;
              req_open  <= open_ok;
              if (n_eff == '0) begin
                done   <= 1'b1;
                status <= ST_ALL_PINNED;
                slot   <= 4'd0;
              end else begin
                state <= S_SCAN;
                idx   <= '0;
                pend  <= 1'b0;
                have  <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          pend <= (idx < n_eff);
          pidx <= idx[AW-1:0];
          idx  <= idx + CW'(1);
          if (pend) begin
            if (res.hit) begin
              pinned_bits[pidx] <= 1'b1;
              done   <= 1'b1;
              status <= ST_HIT;
              slot   <= 4'(pidx);
              state  <= S_IDLE;
              pend   <= 1'b0;
            end else begin
              have <= have_n;
              vic  <= vic_n;
              if (res.take) begin
                best <= stamp_eff;
              end
              if (pend_last) begin
                state <= S_IDLE;
                pend  <= 1'b0;
                done  <= 1'b1;
                if (!have_n) begin
                  status <= ST_ALL_PINNED;
                  slot   <= 4'd0;
                end else if (!req_open) begin
                  status <= ST_OPEN_FAILED;
                  slot   <= 4'd0;
                end else begin
                  status             <= ST_FILLED;
                  slot               <= 4'(vic_n);
                  valid_bits[vic_n]  <= 1'b1;
                  pinned_bits[vic_n] <= 1'b1;
                end
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PLVC_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while scan still running")
  `PLVC_ASSERT_NEXT(a_scan_starts, accept && !mode && req_ok && (n_eff != '0), busy,
                    "valid lookup did not start a scan")
  `PLVC_ASSERT_IMPL(a_clock_nonzero, done && ((status == ST_HIT) || (status == ST_FILLED)),
                    use_clock != '0, "use clock zero after stamping a slot")
  `PLVC_ASSERT_IMPL(a_pend_in_scan, pend, busy, "compare pending outside scan")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pinned lru variant cache
// ----------------------------------------------------------------------------
// A directed sequence covers hits, fills, every kind of invalid word, open
// failure, the all-pinned case and begin layout. Random phases then run key
// pools sized to the active slot count under several register settings,
// including zero and out-of-range values, some with random sender idling.
// A class predicts each result from its own copy of the cache state and
// checks the done words in order.
// ----------------------------------------------------------------------------
module tb;
  import plvc_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_WORDS = 132;

  class variant_cache_model;
    typedef struct {
      logic [2:0] status;
      logic [3:0] slot;
    } result_t;

    bit          slot_valid [SLOTS_DEF];
    logic [3:0]  slot_role [SLOTS_DEF];
    logic [12:0] slot_size [SLOTS_DEF];
    bit          slot_italic [SLOTS_DEF];
    logic [31:0] slot_stamp [SLOTS_DEF];
    bit          slot_pinned [SLOTS_DEF];
    logic [31:0] use_clock;
    logic [4:0]  slots_in_use;
    logic [4:0]  num_roles;
    result_t     pending_results[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        slot_valid[i] = 0;
        slot_role[i] = '0;
        slot_size[i] = '0;
        slot_italic[i] = 0;
        slot_stamp[i] = '0;
        slot_pinned[i] = 0;
      end
      use_clock = '0;
      slots_in_use = 5'd16;
      num_roles = 5'd1;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] val);
      if (idx == REG_SLOTS_IN_USE) begin
        slots_in_use = val;
      end else if (idx == REG_NUM_ROLES) begin
        num_roles = val;
      end
    endfunction

    function result_t predict_lookup(logic m, logic [3:0] r, logic [12:0] px,
                                     logic it, logic ok);
      result_t res;
      int n;
      int nr;
      int victim;
      bit have;
      n = (slots_in_use > SLOTS_DEF) ? SLOTS_DEF : int'(slots_in_use);
      nr = (num_roles > MAX_ROLES_DEF) ? MAX_ROLES_DEF : int'(num_roles);
      res.slot = '0;
      victim = 0;
      have = 0;
      if (m) begin
        for (int i = 0; i < n; i++) slot_pinned[i] = 0;
        res.status = ST_LAYOUT;
        return res;
      end
      if (int'(r) >= nr || px < 13'd1 || px > SIZE_LIMIT) begin
        res.status = ST_INVALID;
        return res;
      end
      use_clock = use_clock + 32'd1;
      if (use_clock == '0) use_clock = 32'd1;
      for (int i = 0; i < n; i++) begin
        if (slot_valid[i] && slot_role[i] == r && slot_size[i] == px &&
            slot_italic[i] == it) begin
          slot_stamp[i] = use_clock;
          slot_pinned[i] = 1;
          res.status = ST_HIT;
          res.slot = i[3:0];
          return res;
        end
        if (!slot_pinned[i] && (!have || slot_stamp[i] < slot_stamp[victim])) begin
          victim = i;
          have = 1;
        end
      end
      if (!have) begin
        res.status = ST_ALL_PINNED;
        return res;
      end
      if (!ok) begin
        res.status = ST_OPEN_FAILED;
        return res;
      end
      slot_valid[victim] = 1;
      slot_role[victim] = r;
      slot_size[victim] = px;
      slot_italic[victim] = it;
      slot_stamp[victim] = use_clock;
      slot_pinned[victim] = 1;
      res.status = ST_FILLED;
      res.slot = victim[3:0];
      return res;
    endfunction

    function void note_word(logic m, logic [3:0] r, logic [12:0] px, logic it,
                            logic ok);
      pending_results.push_back(predict_lookup(m, r, px, it, ok));
    endfunction

    function void check_result(logic [2:0] st, logic [3:0] sl);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d slot %0d", $time, st, sl);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) begin
        $display("%0t status mismatch: expected %0d got %0d", $time, want.status, st);
        errors++;
      end
      if (sl !== want.slot) begin
        $display("%0t slot mismatch: expected %0d got %0d", $time, want.slot, sl);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [3:0]  role_index = '0;
  logic [12:0] pixels = '0;
  logic        italic = 1'b0;
  logic        open_ok = 1'b0;
  logic        done;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  variant_cache_model sb = new();

  logic [3:0]  pool_role [24];
  logic [12:0] pool_px [24];
  logic        pool_it [24];
  int          pool_n;

  pinned_lru_variant_cache u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .role_index(role_index),
    .pixels(pixels),
    .italic(italic),
    .open_ok(open_ok),
    .done(done),
    .status(status),
    .slot(slot),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // results first so a new word never pairs with an older result
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, slot);
      if (start && !busy) sb.note_word(mode, role_index, pixels, italic, open_ok);
    end
  end

  function automatic int unsigned pick_gap(int unsigned pct);
    int unsigned g;
    g = 0;
    while ($urandom_range(99) < pct && g < 30) g++;
    return g;
  endfunction

  task automatic send_word(input logic m, input logic [3:0] r, input logic [12:0] px,
                           input logic it, input logic ok, input int unsigned pct);
    int unsigned g;
    mode <= m;
    role_index <= r;
    pixels <= px;
    italic <= it;
    open_ok <= ok;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    g = pick_gap(pct);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_pool(input int nslots, input int nroles);
    int n;
    int nr;
    n = (nslots > SLOTS_DEF) ? SLOTS_DEF : nslots;
    if (n < 1) n = 1;
    nr = (nroles > MAX_ROLES_DEF) ? MAX_ROLES_DEF : nroles;
    pool_n = n + 4;
    for (int k = 0; k < pool_n; k++) begin
      pool_role[k] = (nr > 0) ? 4'($urandom_range(nr - 1)) : 4'($urandom_range(15));
      case ($urandom_range(9))
        0: pool_px[k] = 13'd1;
        1: pool_px[k] = SIZE_LIMIT;
        2: pool_px[k] = 13'($urandom_range(15, 1));
        default: pool_px[k] = 13'($urandom_range(4096, 1));
      endcase
      pool_it[k] = 1'($urandom_range(1));
    end
  endtask

  task automatic random_word(input int unsigned pct);
    int unsigned pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_word(1'b1, 4'($urandom), 13'($urandom), 1'($urandom), 1'($urandom), pct);
    end else if (pick < 18) begin
      send_word(1'b0, 4'($urandom), 13'($urandom), 1'($urandom), 1'($urandom), pct);
    end else begin
      k = $urandom_range(pool_n - 1);
      send_word(1'b0, pool_role[k], pool_px[k], pool_it[k],
                $urandom_range(99) < 85, pct);
    end
  endtask

  initial begin
    int ph_slots [NUM_PHASES];
    int ph_roles [NUM_PHASES];
    int unsigned ph_idle [4];
    ph_slots = '{4, 1, 16, 31, 0, 8, 7, 16};
    ph_roles = '{16, 3, 16, 20, 5, 0, 9, 1};
    ph_idle = '{0, 76, 0, 28};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 16 slots, one role
    send_word(1'b1, 4'd15, 13'd8191, 1'b1, 1'b0, 0);
    send_word(1'b0, 4'd0, 13'd1, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd0, 13'd1, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd0, SIZE_LIMIT, 1'b1, 1'b1, 0);
    send_word(1'b0, 4'd0, 13'd0, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd0, 13'd4097, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd0, 13'd8191, 1'b1, 1'b1, 0);
    send_word(1'b0, 4'd1, 13'd100, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd15, 13'd100, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd0, 13'd100, 1'b0, 1'b0, 0);
    send_word(1'b1, 4'd0, 13'd0, 1'b0, 1'b1, 0);
    drain();

    // two slots, all roles: eviction, all pinned, ignored register indexes
    write_reg(REG_SLOTS_IN_USE, 5'd2);
    write_reg(REG_NUM_ROLES, 5'd16);
    write_reg(REG_SPARE_A, 5'd31);
    write_reg(REG_SPARE_B, 5'd0);
    send_word(1'b0, 4'd15, SIZE_LIMIT, 1'b1, 1'b1, 0);
    send_word(1'b0, 4'd3, 13'd50, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd4, 13'd60, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd15, SIZE_LIMIT, 1'b1, 1'b1, 0);
    send_word(1'b1, 4'd0, 13'd0, 1'b0, 1'b0, 0);
    send_word(1'b0, 4'd4, 13'd60, 1'b0, 1'b0, 0);
    send_word(1'b0, 4'd4, 13'd60, 1'b0, 1'b1, 0);
    send_word(1'b0, 4'd15, SIZE_LIMIT, 1'b0, 1'b1, 0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_SLOTS_IN_USE, 5'(ph_slots[p]));
      write_reg(REG_NUM_ROLES, 5'(ph_roles[p]));
      if (p == 3) write_reg(REG_SPARE_B, 5'd21);
      build_pool(ph_slots[p], ph_roles[p]);
      for (int w = 0; w < PHASE_WORDS; w++) random_word(ph_idle[p % 4]);
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pinned_lru_variant_cache");
    end else begin
      $display("FAIL pinned_lru_variant_cache");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL pinned_lru_variant_cache");
    $finish;
  end

endmodule
